// File: rtl/ptd_pkg.sv
// Shared types, constants and reset values for the periodic task dispatcher.
package ptd_pkg;

    // Task table size and time arithmetic width.
    localparam int NUM_TASKS = 7;
    localparam int TIME_BITS = 32;
    localparam int TASK_W    = 3;
    localparam int CFG_W     = 32;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [TASK_W-1:0]    task_idx_t;
    typedef logic [CFG_W-1:0]     period_t;

    // Operation codes carried by an input beat.
    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Result kinds reported on the output beat.
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_FINISH   = 2'd2,
        KIND_REJECT   = 2'd3
    } kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MINMAX,
        ST_SUMS,
        ST_SCAN,
        ST_RESPOND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  capture;
        logic  decide;
        kind_t kind;
        logic  minmax;
        logic  sums;
        logic  scan_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;
        logic running;
        logic ready_pos;
        logic scan_end;
    } status_t;

    // Period register values after reset.
    function automatic period_t period_reset(input int unsigned k);
        period_t value;
        case (k)
            0:       value = period_t'(1000 * 1000);
            1:       value = period_t'(250);
            2:       value = period_t'(1000 * 1);
            3:       value = period_t'(1000 * 10);
            4:       value = period_t'(1000 * 1);
            5:       value = period_t'(1000 * 1);
            6:       value = period_t'(1000 * 100);
            default: value = '0;
        endcase
        return value;
    endfunction

endpackage

// File: rtl/periodic_task_dispatcher_unit.sv
// Top level of the periodic task dispatcher: controller plus datapath.
//
// Usage: an event beat (operation, now) is accepted at a rising edge where
// start is high and busy is low. operation 0 polls for the next dispatch,
// operation 1 reports that the running task has finished. Exactly one
// result beat follows each event, shown for one cycle with done high.
// The receiver cannot stall; each result must be taken in that cycle.
// Controller states after the accepting edge, with done high in RESPOND:
//   rejected poll or finish, or a dispatching poll: DECIDE, RESPOND,
//   poll that dispatches nothing: DECIDE, SCAN, RESPOND,
//   accepted finish: DECIDE, MINMAX, SUMS, SCAN, RESPOND.
// The variable part is the readiness scan, which checks one task per cycle
// with a single elapsed-time subtract and period compare; it stops early at
// the first due task below the scan position. A new event can be accepted
// in the cycle after done.
// Periods are written over the cfg channel (cfg_index 0..6; other indexes
// are ignored), which is always ready; writes belong in idle time.
// Reset restores the reset periods, marks every task ready, clears start times,
// longest runs and sums; shortest runs go to all ones, scan position to 0.
module periodic_task_dispatcher_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  ptd_pkg::time_t           now,
    output logic                     done,
    output logic [1:0]               result_kind,
    output ptd_pkg::task_idx_t       task_index,
    output ptd_pkg::time_t           since_last_start,
    output ptd_pkg::time_t           run_time,
    output ptd_pkg::time_t           run_time_most,
    output ptd_pkg::time_t           run_time_least,
    output ptd_pkg::time_t           total_run_time,
    output ptd_pkg::time_t           total_of_most,
    output ptd_pkg::time_t           total_of_least,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  ptd_pkg::task_idx_t       cfg_index,
    input  ptd_pkg::period_t         cfg_data
);

    ptd_pkg::cmd_t    cmd;
    ptd_pkg::status_t status;
    logic             cfg_we;

    // Configuration writes complete in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ptd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ptd_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .operation        (operation),
        .now              (now),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_kind      (result_kind),
        .task_index       (task_index),
        .since_last_start (since_last_start),
        .run_time         (run_time),
        .run_time_most    (run_time_most),
        .run_time_least   (run_time_least),
        .total_run_time   (total_run_time),
        .total_of_most    (total_of_most),
        .total_of_least   (total_of_least)
    );

endmodule

// File: rtl/ptd_ctrl.sv
// Controller state machine that sequences one dispatcher event at a time.
module ptd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ptd_pkg::status_t  status,
    output ptd_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done
);

    ptd_pkg::state_t state_reg;
    ptd_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ptd_pkg::ST_DECIDE;
                end
            end
            ptd_pkg::ST_DECIDE:
            begin
                if (status.op == ptd_pkg::OP_POLL)
                begin
                    if (status.running || status.ready_pos)
                    begin
                        state_next = ptd_pkg::ST_RESPOND;
                    end
                    else
                    begin
                        state_next = ptd_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    if (status.running)
                    begin
                        state_next = ptd_pkg::ST_MINMAX;
                    end
                    else
                    begin
                        state_next = ptd_pkg::ST_RESPOND;
                    end
                end
            end
            ptd_pkg::ST_MINMAX:
            begin
                state_next = ptd_pkg::ST_SUMS;
            end
            ptd_pkg::ST_SUMS:
            begin
                state_next = ptd_pkg::ST_SCAN;
            end
            ptd_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ptd_pkg::ST_RESPOND;
                end
            end
            ptd_pkg::ST_RESPOND:
            begin
                state_next = ptd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptd_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: datapath commands and handshake flags.
    always_comb
    begin
        cmd      = '0;
        cmd.kind = ptd_pkg::KIND_NONE;
        busy     = 1'b1;
        done     = 1'b0;
        unique case (state_reg)
            ptd_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ptd_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.op == ptd_pkg::OP_POLL)
                begin
                    if (status.running)
                    begin
                        cmd.kind = ptd_pkg::KIND_REJECT;
                    end
                    else if (status.ready_pos)
                    begin
                        cmd.kind = ptd_pkg::KIND_DISPATCH;
                    end
                    else
                    begin
                        cmd.kind = ptd_pkg::KIND_NONE;
                    end
                end
                else
                begin
                    if (status.running)
                    begin
                        cmd.kind = ptd_pkg::KIND_FINISH;
                    end
                    else
                    begin
                        cmd.kind = ptd_pkg::KIND_REJECT;
                    end
                end
            end
            ptd_pkg::ST_MINMAX:
            begin
                cmd.minmax = 1'b1;
            end
            ptd_pkg::ST_SUMS:
            begin
                cmd.sums = 1'b1;
            end
            ptd_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ptd_pkg::ST_RESPOND:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // An accepted beat makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not make the block busy");

    // After a result strobe the block is ready for a new beat.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result strobe");

    // A rejected poll is answered on the cycle after the decision.
    a_reject_fast: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && status.op == ptd_pkg::OP_POLL && status.running |=> done)
        else $error("rejected poll not answered promptly");

    // Sums are only updated right after the min and max step.
    a_sums_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sums |-> $past(cmd.minmax))
        else $error("sum update without preceding min and max step");

endmodule

// File: rtl/ptd_datapath.sv
// Datapath with the task table, statistics, readiness scan and result registers.
module ptd_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ptd_pkg::cmd_t                cmd,
    output ptd_pkg::status_t             status,
    input  logic                         operation,
    input  ptd_pkg::time_t               now,
    input  logic                         cfg_we,
    input  ptd_pkg::task_idx_t           cfg_index,
    input  ptd_pkg::period_t             cfg_data,
    output logic [1:0]                   result_kind,
    output ptd_pkg::task_idx_t           task_index,
    output ptd_pkg::time_t               since_last_start,
    output ptd_pkg::time_t               run_time,
    output ptd_pkg::time_t               run_time_most,
    output ptd_pkg::time_t               run_time_least,
    output ptd_pkg::time_t               total_run_time,
    output ptd_pkg::time_t               total_of_most,
    output ptd_pkg::time_t               total_of_least
);

    // Per-task table.
    ptd_pkg::period_t   period_reg     [ptd_pkg::NUM_TASKS];
    logic               ready_reg      [ptd_pkg::NUM_TASKS];
    ptd_pkg::time_t     last_start_reg [ptd_pkg::NUM_TASKS];
    ptd_pkg::time_t     most_reg       [ptd_pkg::NUM_TASKS];
    ptd_pkg::time_t     least_reg      [ptd_pkg::NUM_TASKS];

    // Scheduler state.
    ptd_pkg::task_idx_t pos_reg;
    ptd_pkg::task_idx_t scan_idx_reg;
    logic               running_reg;
    ptd_pkg::time_t     sum_used_reg;
    ptd_pkg::time_t     sum_most_reg;
    ptd_pkg::time_t     sum_least_reg;

    // Captured input beat.
    logic               op_reg;
    ptd_pkg::time_t     now_reg;

    // Result registers.
    ptd_pkg::kind_t     kind_reg;
    ptd_pkg::task_idx_t idx_reg;
    ptd_pkg::time_t     since_reg;
    ptd_pkg::time_t     run_reg;
    ptd_pkg::time_t     most_out_reg;
    ptd_pkg::time_t     least_out_reg;
    ptd_pkg::time_t     total_run_reg;
    ptd_pkg::time_t     total_most_reg;
    ptd_pkg::time_t     total_least_reg;

    // Combinational values.
    ptd_pkg::task_idx_t pos_eff;
    ptd_pkg::task_idx_t pos_inc;
    ptd_pkg::time_t     used;
    ptd_pkg::time_t     most_next;
    ptd_pkg::time_t     least_next;
    ptd_pkg::time_t     sum_used_next;
    ptd_pkg::time_t     sum_most_next;
    ptd_pkg::time_t     sum_least_next;
    ptd_pkg::time_t     scan_elapsed;
    logic               scan_due;
    logic               scan_hit;
    logic               scan_last;
    logic               cfg_hit;

    // Scan position, elapsed time at that position and the statistics updates.
    always_comb
    begin
        pos_eff = (pos_reg >= ptd_pkg::TASK_W'(ptd_pkg::NUM_TASKS)) ? '0 : pos_reg;
        pos_inc = (pos_eff == ptd_pkg::TASK_W'(ptd_pkg::NUM_TASKS - 1)) ? '0
                : pos_eff + ptd_pkg::TASK_W'(1);
        used       = now_reg - last_start_reg[pos_eff];
        most_next  = (used > most_reg[pos_eff]) ? used : most_reg[pos_eff];
        least_next = (used < least_reg[pos_eff]) ? used : least_reg[pos_eff];
        sum_used_next  = sum_used_reg + run_reg;
        sum_most_next  = sum_most_reg + most_out_reg;
        sum_least_next = sum_least_reg + least_out_reg;
    end

    // One task of the readiness scan per cycle.
    always_comb
    begin
        scan_elapsed = now_reg - last_start_reg[scan_idx_reg];
        scan_due     = ptd_pkg::period_t'(scan_elapsed) >= period_reg[scan_idx_reg];
        scan_hit     = scan_due && (scan_idx_reg < pos_eff);
        scan_last    = scan_idx_reg == ptd_pkg::TASK_W'(ptd_pkg::NUM_TASKS - 1);
        cfg_hit      = cfg_we && (cfg_index < ptd_pkg::TASK_W'(ptd_pkg::NUM_TASKS));
    end

    // Status back to the controller.
    always_comb
    begin
        status.op        = op_reg;
        status.running   = running_reg;
        status.ready_pos = ready_reg[pos_eff];
        status.scan_end  = scan_hit || scan_last;
    end

    // Input beat capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            now_reg <= now;
        end
    end

    // Task table and scheduler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ptd_pkg::NUM_TASKS; k++)
            begin
                period_reg[k]     <= ptd_pkg::period_reset(k);
                ready_reg[k]      <= 1'b1;
                last_start_reg[k] <= '0;
                most_reg[k]       <= '0;
                least_reg[k]      <= '1;
            end
            pos_reg       <= '0;
            scan_idx_reg  <= '0;
            running_reg   <= 1'b0;
            sum_used_reg  <= '0;
            sum_most_reg  <= '0;
            sum_least_reg <= '0;
        end
        else
        begin
            if (cfg_hit)
            begin
                period_reg[cfg_index] <= cfg_data;
            end
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
            end
            if (cmd.decide)
            begin
                pos_reg <= pos_eff;
                if (cmd.kind == ptd_pkg::KIND_DISPATCH)
                begin
                    last_start_reg[pos_eff] <= now_reg;
                    ready_reg[pos_eff]      <= 1'b0;
                    running_reg             <= 1'b1;
                end
            end
            if (cmd.minmax)
            begin
                most_reg[pos_eff]  <= most_next;
                least_reg[pos_eff] <= least_next;
                ready_reg[pos_eff] <= 1'b0;
                running_reg        <= 1'b0;
            end
            if (cmd.sums)
            begin
                sum_used_reg  <= sum_used_next;
                sum_most_reg  <= sum_most_next;
                sum_least_reg <= sum_least_next;
            end
            if (cmd.scan_step)
            begin
                if (scan_due)
                begin
                    ready_reg[scan_idx_reg] <= 1'b1;
                end
                if (scan_hit)
                begin
                    pos_reg <= scan_idx_reg;
                end
                else if (scan_last)
                begin
                    pos_reg <= pos_inc;
                end
                // The scan index stays on the last task so it always names a real entry.
                if (!scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + ptd_pkg::TASK_W'(1);
                end
            end
        end
    end

    // Result registers: every field not belonging to the kind reads as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            kind_reg        <= cmd.kind;
            idx_reg         <= (cmd.kind == ptd_pkg::KIND_DISPATCH
                                || cmd.kind == ptd_pkg::KIND_FINISH) ? pos_eff : '0;
            since_reg       <= (cmd.kind == ptd_pkg::KIND_DISPATCH) ? used : '0;
            run_reg         <= (cmd.kind == ptd_pkg::KIND_FINISH) ? used : '0;
            most_out_reg    <= '0;
            least_out_reg   <= '0;
            total_run_reg   <= '0;
            total_most_reg  <= '0;
            total_least_reg <= '0;
        end
        if (cmd.minmax)
        begin
            most_out_reg  <= most_next;
            least_out_reg <= least_next;
        end
        if (cmd.sums)
        begin
            total_run_reg   <= sum_used_next;
            total_most_reg  <= sum_most_next;
            total_least_reg <= sum_least_next;
        end
    end

    assign result_kind      = kind_reg;
    assign task_index       = idx_reg;
    assign since_last_start = since_reg;
    assign run_time         = run_reg;
    assign run_time_most    = most_out_reg;
    assign run_time_least   = least_out_reg;
    assign total_run_time   = total_run_reg;
    assign total_of_most    = total_most_reg;
    assign total_of_least   = total_least_reg;

    // The scan position always names a real task.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < ptd_pkg::TASK_W'(ptd_pkg::NUM_TASKS))
        else $error("scan position beyond the task list");

    // A finish step always leaves no task running.
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.minmax |=> !running_reg)
        else $error("task still running after finish");

    // A dispatch marks a task running and clears its ready mark.
    a_dispatch_sets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && cmd.kind == ptd_pkg::KIND_DISPATCH |=> running_reg)
        else $error("dispatch did not mark a task running");

endmodule

// File: bench/ptd_checker.sv
// Watcher for the periodic task dispatcher: predicts every result beat and compares it.
`timescale 1ns / 1ps

module ptd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               operation,
    input  ptd_pkg::time_t     now,
    input  logic               done,
    input  logic [1:0]         result_kind,
    input  ptd_pkg::task_idx_t task_index,
    input  ptd_pkg::time_t     since_last_start,
    input  ptd_pkg::time_t     run_time,
    input  ptd_pkg::time_t     run_time_most,
    input  ptd_pkg::time_t     run_time_least,
    input  ptd_pkg::time_t     total_run_time,
    input  ptd_pkg::time_t     total_of_most,
    input  ptd_pkg::time_t     total_of_least,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  ptd_pkg::task_idx_t cfg_index,
    input  ptd_pkg::period_t   cfg_data,
    output int                 mismatches,
    output int                 results_owed,
    output ptd_pkg::kind_t     latest_kind
);

    // One predicted result beat.
    typedef struct packed {
        ptd_pkg::kind_t     kind;
        ptd_pkg::task_idx_t idx;
        ptd_pkg::time_t     since;
        ptd_pkg::time_t     used;
        ptd_pkg::time_t     most;
        ptd_pkg::time_t     least;
        ptd_pkg::time_t     sum_used;
        ptd_pkg::time_t     sum_most;
        ptd_pkg::time_t     sum_least;
    } dispatch_beat_t;

    // Shadow copy of the scheduler state and the period registers.
    ptd_pkg::period_t   period       [ptd_pkg::NUM_TASKS];
    logic               ready        [ptd_pkg::NUM_TASKS];
    ptd_pkg::time_t     last_start   [ptd_pkg::NUM_TASKS];
    ptd_pkg::time_t     longest_run  [ptd_pkg::NUM_TASKS];
    ptd_pkg::time_t     shortest_run [ptd_pkg::NUM_TASKS];
    ptd_pkg::task_idx_t scan_pos;
    logic               running;
    ptd_pkg::time_t     total_used;
    ptd_pkg::time_t     total_most;
    ptd_pkg::time_t     total_least;
    dispatch_beat_t     awaited_beats[$];

    initial mismatches = 0;

    function automatic void clear_schedule();
        for (int k = 0; k < ptd_pkg::NUM_TASKS; k++)
        begin
            period[k]       = ptd_pkg::period_reset(k);
            ready[k]        = 1'b1;
            last_start[k]   = '0;
            longest_run[k]  = '0;
            shortest_run[k] = '1;
        end
        scan_pos    = '0;
        running     = 1'b0;
        total_used  = '0;
        total_most  = '0;
        total_least = '0;
    endfunction

    // Mark tasks whose period has elapsed, in order; stop and jump back at the first
    // one below the scan position, otherwise step the position with wrap.
    function automatic void mark_due_tasks(ptd_pkg::time_t t);
        ptd_pkg::time_t elapsed;
        for (int j = 0; j < ptd_pkg::NUM_TASKS; j++)
        begin
            elapsed = t - last_start[j];
            if (elapsed >= period[j])
            begin
                ready[j] = 1'b1;
                if (j < scan_pos)
                begin
                    scan_pos = ptd_pkg::task_idx_t'(j);
                    return;
                end
            end
        end
        scan_pos = (scan_pos == ptd_pkg::NUM_TASKS - 1) ? ptd_pkg::task_idx_t'(0)
                 : scan_pos + ptd_pkg::task_idx_t'(1);
    endfunction

    // Work out the result of one event and advance the shadow state.
    function automatic dispatch_beat_t schedule_event(logic op, ptd_pkg::time_t t);
        dispatch_beat_t     r;
        ptd_pkg::task_idx_t p;
        ptd_pkg::time_t     used;
        r = '0;
        p = scan_pos;
        if (op == ptd_pkg::OP_POLL)
        begin
            if (running)
                r.kind = ptd_pkg::KIND_REJECT;
            else if (ready[p])
            begin
                r.kind        = ptd_pkg::KIND_DISPATCH;
                r.idx         = p;
                r.since       = t - last_start[p];
                last_start[p] = t;
                ready[p]      = 1'b0;
                running       = 1'b1;
            end
            else
            begin
                r.kind = ptd_pkg::KIND_NONE;
                mark_due_tasks(t);
            end
        end
        else if (!running)
            r.kind = ptd_pkg::KIND_REJECT;
        else
        begin
            used = t - last_start[p];
            if (used > longest_run[p])
                longest_run[p] = used;
            if (used < shortest_run[p])
                shortest_run[p] = used;
            total_used  = total_used + used;
            total_most  = total_most + longest_run[p];
            total_least = total_least + shortest_run[p];
            ready[p]    = 1'b0;
            running     = 1'b0;
            r.kind      = ptd_pkg::KIND_FINISH;
            r.idx       = p;
            r.used      = used;
            r.most      = longest_run[p];
            r.least     = shortest_run[p];
            r.sum_used  = total_used;
            r.sum_most  = total_most;
            r.sum_least = total_least;
            mark_due_tasks(t);
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    // Result beats are compared before the event of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        dispatch_beat_t exp_beat;
        if (!rst_n)
        begin
            clear_schedule();
            awaited_beats.delete();
            results_owed <= 0;
            latest_kind  <= ptd_pkg::KIND_NONE;
        end
        else
        begin
            if (done)
            begin
                latest_kind <= ptd_pkg::kind_t'(result_kind);
                if (awaited_beats.size() == 0)
                begin
                    $error("result beat with no event outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_beat = awaited_beats.pop_front();
                    check_field("result_kind", 32'(exp_beat.kind), 32'(result_kind));
                    check_field("task_index", 32'(exp_beat.idx), 32'(task_index));
                    check_field("since_last_start", exp_beat.since, since_last_start);
                    check_field("run_time", exp_beat.used, run_time);
                    check_field("run_time_most", exp_beat.most, run_time_most);
                    check_field("run_time_least", exp_beat.least, run_time_least);
                    check_field("total_run_time", exp_beat.sum_used, total_run_time);
                    check_field("total_of_most", exp_beat.sum_most, total_of_most);
                    check_field("total_of_least", exp_beat.sum_least, total_of_least);
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < ptd_pkg::NUM_TASKS)
                period[cfg_index] = cfg_data;
            if (start && !busy)
                awaited_beats.push_back(schedule_event(operation, now));
            results_owed <= awaited_beats.size();
        end
    end

endmodule

// File: bench/tb_periodic_task_dispatcher_unit.sv
// Top of the dispatcher testbench: clock, reset, event and period stimulus, verdict.
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher_unit;

    localparam int                 CYCLE_LIMIT  = 300000;
    localparam int                 PHASE_EVENTS = 56;
    localparam ptd_pkg::task_idx_t SPARE_INDEX  = 3'd7;

    // How the period registers are loaded for one phase.
    typedef enum int {
        PER_RESET,
        PER_ZERO,
        PER_FULL,
        PER_SHORT,
        PER_MIXED
    } period_plan_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               operation;
    ptd_pkg::time_t     now;
    logic               done;
    logic [1:0]         result_kind;
    ptd_pkg::task_idx_t task_index;
    ptd_pkg::time_t     since_last_start;
    ptd_pkg::time_t     run_time;
    ptd_pkg::time_t     run_time_most;
    ptd_pkg::time_t     run_time_least;
    ptd_pkg::time_t     total_run_time;
    ptd_pkg::time_t     total_of_most;
    ptd_pkg::time_t     total_of_least;
    logic               cfg_valid;
    logic               cfg_ready;
    ptd_pkg::task_idx_t cfg_index;
    ptd_pkg::period_t   cfg_data;
    int                 mismatches;
    int                 results_owed;
    ptd_pkg::kind_t     latest_kind;

    ptd_pkg::time_t     wall_clock;
    int                 cycle_count;

    periodic_task_dispatcher_unit dut (.*);
    ptd_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog on total run length.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_periodic_task_dispatcher_unit: done, errors");
            $finish;
        end
    end

    // Mostly small timer steps, with long jumps, random values and steps back.
    function automatic ptd_pkg::time_t advance_clock();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            wall_clock = wall_clock + $urandom_range(0, 300);
        else if (pick < 80)
            wall_clock = wall_clock + $urandom_range(0, 3000);
        else if (pick < 88)
            wall_clock = wall_clock + $urandom_range(0, 200000);
        else if (pick < 94)
            wall_clock = $urandom();
        else if (pick < 97)
            wall_clock = wall_clock - $urandom_range(1, 1000);
        return wall_clock;
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Lower start when a pause or a drain comes before the next event beat.
    task automatic idle_before(bit drain, int gap);
        if (drain || gap > 0)
        begin
            start <= 1'b0;
            if (drain)
                do @(posedge clk); while (results_owed != 0);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue_event(logic op, ptd_pkg::time_t t);
        start     <= 1'b1;
        operation <= op;
        now       <= t;
        do @(posedge clk); while (busy);
    endtask

    // Load every period register plus the unused index, back to back.
    task automatic program_periods(period_plan_t plan);
        ptd_pkg::period_t value;
        for (int k = 0; k <= ptd_pkg::NUM_TASKS; k++)
        begin
            case (plan)
                PER_RESET: value = ptd_pkg::period_reset(k);
                PER_ZERO:  value = '0;
                PER_FULL:  value = '1;
                PER_SHORT: value = $urandom_range(0, 800);
                default:
                    case ($urandom_range(0, 3))
                        0:       value = '0;
                        1:       value = '1;
                        2:       value = $urandom_range(1, 5000);
                        default: value = $urandom();
                    endcase
            endcase
            if (k == ptd_pkg::NUM_TASKS)
                value = $urandom();
            cfg_valid <= 1'b1;
            cfg_index <= (k == ptd_pkg::NUM_TASKS) ? SPARE_INDEX : ptd_pkg::task_idx_t'(k);
            cfg_data  <= value;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly poll/finish pairs that follow the last result, some random noise.
    task automatic run_phase(bit calm);
        bit   follow;
        logic op;
        for (int i = 0; i < PHASE_EVENTS; i++)
        begin
            follow = ($urandom_range(0, 99) >= 15);
            idle_before(follow, calm ? 0 : pick_gap());
            if (follow)
                op = (latest_kind == ptd_pkg::KIND_DISPATCH) ? ptd_pkg::OP_FINISH
                   : ptd_pkg::OP_POLL;
            else
                op = 1'($urandom_range(0, 1));
            issue_event(op, advance_clock());
        end
    endtask

    // Directed opening: rejects, wrap of run and start times, zero run time.
    logic  seed_ops   [22] = '{ptd_pkg::OP_FINISH, ptd_pkg::OP_POLL, ptd_pkg::OP_POLL,
                               ptd_pkg::OP_FINISH, ptd_pkg::OP_POLL, ptd_pkg::OP_FINISH,
                               ptd_pkg::OP_POLL, ptd_pkg::OP_FINISH, ptd_pkg::OP_POLL,
                               ptd_pkg::OP_POLL, ptd_pkg::OP_FINISH, ptd_pkg::OP_POLL,
                               ptd_pkg::OP_FINISH, ptd_pkg::OP_POLL, ptd_pkg::OP_POLL,
                               ptd_pkg::OP_FINISH, ptd_pkg::OP_POLL, ptd_pkg::OP_FINISH,
                               ptd_pkg::OP_POLL, ptd_pkg::OP_FINISH, ptd_pkg::OP_POLL,
                               ptd_pkg::OP_POLL};
    ptd_pkg::time_t seed_times [22] = '{32'd0, 32'd0, 32'd3, 32'd5, 32'd10, 32'hFFFF_FFF0,
                               32'hFFFF_FFFF, 32'd0, 32'd40, 32'd80, 32'd300, 32'd600,
                               32'd2000, 32'd2500, 32'd2600, 32'd2600, 32'd1200000,
                               32'd1200001, 32'd1200002, 32'd80000000, 32'd80000001,
                               32'd80000002};

    period_plan_t phase_plans [8] = '{PER_ZERO, PER_SHORT, PER_FULL, PER_MIXED,
                                      PER_SHORT, PER_RESET, PER_MIXED, PER_SHORT};

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        operation <= ptd_pkg::OP_POLL;
        now       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events under the reset periods.
        for (int i = 0; i < 22; i++)
        begin
            idle_before(i % 3 == 0, 0);
            wall_clock = seed_times[i];
            issue_event(seed_ops[i], seed_times[i]);
        end

        // Random phases, each under its own period setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_before(1'b1, 0);
            repeat (4) @(posedge clk);
            program_periods(phase_plans[ph]);
            run_phase(ph == 1);
        end

        idle_before(1'b1, 0);
        repeat (12) @(posedge clk);
        if (mismatches == 0 && results_owed == 0)
            $display("tb_periodic_task_dispatcher_unit: done, clean");
        else
            $display("tb_periodic_task_dispatcher_unit: done, errors");
        $finish;
    end

endmodule
